// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an implication holds in the cycle after the antecedent, outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svbr_pkg.sv
package svbr_pkg;

  // Q30 constants for the angle conversion and the sine and cosine series.
  localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
  localparam logic [31:0] ONE_Q30 = 32'h40000000;
  localparam int          TERMS   = 11;

  // Taylor term divisors for sine and cosine, indexed by term number.
  function automatic logic [9:0] sin_div(input int k);
    sin_div = 10'((2 * k) * (2 * k + 1));
  endfunction

  function automatic logic [9:0] cos_div(input int k);
    cos_div = 10'((2 * k - 1) * (2 * k));
  endfunction

  // Direction codes of the configuration register.
  typedef enum logic {
    DIR_CART_TO_SPH = 1'b0,
    DIR_SPH_TO_CART = 1'b1
  } dir_t;

endpackage

// File: hdl/svbr_sincos.sv
// Sine and cosine of an angle in Q30, quadrant folded.
module svbr_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ANGLE_BITS-1:0]        angle,
  output logic signed [31:0]           sin_q30,
  output logic signed [31:0]           cos_q30
);
  import svbr_pkg::*;

  localparam int QSH = ANGLE_BITS - 2;
  localparam int N   = TERMS + 1;

  // Stage 0: angle to radians.
  logic [1:0]  quad0;
  logic [31:0] x0;
  logic [QSH+32:0] xprod;
  assign xprod = {1'b0, angle[QSH-1:0]} * {1'b0, PI_Q30}
               + ((QSH+33)'(1) << QSH);

  always_ff @(posedge clk) begin
    if (en) begin
      quad0 <= angle[ANGLE_BITS-1 -: 2];
      x0    <= 32'(xprod >> (ANGLE_BITS - 1));
    end
  end

  // Stage 1: square of x.
  logic [1:0]  quad1;
  logic [31:0] x1, x2;
  logic [63:0] sq;
  assign sq = x0 * x0;
  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= quad0;
      x1    <= x0;
      x2    <= 32'(sq >> 30);
    end
  end

  // Series stages: one term of each series per pair of stages.
  logic [1:0]         qd [N];
  logic [31:0]        ts [N];
  logic [31:0]        tc [N];
  logic signed [33:0] ss [N];
  logic signed [33:0] cs [N];
  logic [31:0]        xs [N];

  assign qd[0] = quad1;
  assign ts[0] = x1;
  assign tc[0] = ONE_Q30;
  assign ss[0] = 34'(x1);
  assign cs[0] = 34'(ONE_Q30);
  assign xs[0] = x2;

  for (genvar k = 1; k < N; k++) begin : g_term
    // Reciprocals of this term's divisors, exact for any 32-bit dividend.
    localparam int SDIV = int'(sin_div(k));
    localparam int CDIV = int'(cos_div(k));
    localparam int SSH  = 32 + $clog2(SDIV);
    localparam int CSH  = 32 + $clog2(CDIV);
    localparam logic [32:0] SREC = 33'(((64'd1 << SSH) + 64'(SDIV) - 64'd1) / 64'(SDIV));
    localparam logic [32:0] CREC = 33'(((64'd1 << CSH) + 64'(CDIV) - 64'd1) / 64'(CDIV));

    logic [63:0]        pts, ptc;
    logic [31:0]        hts, htc, hxs;
    logic [1:0]         hqd;
    logic signed [33:0] hss, hcs;
    logic [64:0]        qts, qtc;
    logic [31:0]        nts, ntc;

    // First stage: product of the previous term with x squared.
    assign pts = ts[k-1] * xs[k-1];
    assign ptc = tc[k-1] * xs[k-1];
    always_ff @(posedge clk) begin
      if (en) begin
        hqd <= qd[k-1];
        hxs <= xs[k-1];
        hts <= 32'(pts >> 30);
        htc <= 32'(ptc >> 30);
        hss <= ss[k-1];
        hcs <= cs[k-1];
      end
    end

    // Second stage: division by a small constant through its reciprocal.
    assign qts = 65'(hts) * 65'(SREC);
    assign qtc = 65'(htc) * 65'(CREC);
    assign nts = 32'(qts >> SSH);
    assign ntc = 32'(qtc >> CSH);
    always_ff @(posedge clk) begin
      if (en) begin
        qd[k] <= hqd;
        xs[k] <= hxs;
        ts[k] <= nts;
        tc[k] <= ntc;
        if (k % 2 == 1) begin
          ss[k] <= hss - 34'(nts);
          cs[k] <= hcs - 34'(ntc);
        end else begin
          ss[k] <= hss + 34'(nts);
          cs[k] <= hcs + 34'(ntc);
        end
      end
    end
  end

  // Clamp and quadrant symmetry.
  logic signed [31:0] s0, c0;
  always_comb begin
    s0 = (ss[N-1] < 0) ? 32'sd0 :
         (ss[N-1] > 34'(ONE_Q30)) ? 32'(ONE_Q30) : 32'(ss[N-1]);
    c0 = (cs[N-1] < 0) ? 32'sd0 :
         (cs[N-1] > 34'(ONE_Q30)) ? 32'(ONE_Q30) : 32'(cs[N-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[N-1])
        2'd0: begin sin_q30 <= s0;  cos_q30 <= c0;  end
        2'd1: begin sin_q30 <= c0;  cos_q30 <= -s0; end
        2'd2: begin sin_q30 <= -s0; cos_q30 <= -c0; end
        default: begin sin_q30 <= -c0; cos_q30 <= s0; end
      endcase
    end
  end
endmodule

// File: hdl/svbr_lane.sv
// One lane: rotates a three component vector by the coefficient matrix.
module svbr_lane #(
  parameter int DATA_BITS = 32,
  parameter int COEF_BITS = 29
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COEF_BITS+1:0] m [3][3],
  input  logic                        transpose,
  input  logic signed [DATA_BITS-1:0] vin [3],
  output logic signed [DATA_BITS-1:0] vout [3]
);
  import svbr_pkg::*;

  localparam int PW = DATA_BITS + COEF_BITS + 2;
  localparam int AW = PW + 2;

  // Products, registered.
  logic signed [PW-1:0] p [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) p[i][j] <= PW'(vin[j]) * PW'(transpose ? m[j][i] : m[i][j]);
      end
    end
  end

  // Sum, round and saturate.
  localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (DATA_BITS - 1)) - 1);
  localparam logic signed [AW-1:0] LO = -HI - 1;
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic signed [AW-1:0] acc, r;
    assign acc = AW'(p[i][0]) + AW'(p[i][1]) + AW'(p[i][2])
               + (AW'(1) <<< (COEF_BITS - 1));
    assign r = acc >>> COEF_BITS;
    always_ff @(posedge clk) begin
      if (en) vout[i] <= (r > HI) ? DATA_BITS'(HI) :
                         (r < LO) ? DATA_BITS'(LO) : DATA_BITS'(r);
    end
  end
endmodule

// File: hdl/spherical_vector_basis_rotation.sv
// Pipeline from input transfer to result valid: 25 sine/cosine
// stages (two per series term), a matrix stage and two lane stages.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output result is not taken.
// Reset: rst clears the valid pipeline and sets direction to Cartesian to
// spherical.
module spherical_vector_basis_rotation #(
  parameter int ANGLE_BITS = 16,
  parameter int DATA_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ANGLE_BITS-1:0]       polar_angle,
  input  logic [ANGLE_BITS-1:0]       azimuth_angle,
  input  logic signed [DATA_BITS-1:0] density_in,
  input  logic signed [DATA_BITS-1:0] pressure_in,
  input  logic signed [DATA_BITS-1:0] vel_a_in,
  input  logic signed [DATA_BITS-1:0] vel_b_in,
  input  logic signed [DATA_BITS-1:0] vel_c_in,
  input  logic signed [DATA_BITS-1:0] mag_a_in,
  input  logic signed [DATA_BITS-1:0] mag_b_in,
  input  logic signed [DATA_BITS-1:0] mag_c_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_BITS-1:0] density_out,
  output logic signed [DATA_BITS-1:0] pressure_out,
  output logic signed [DATA_BITS-1:0] vel_a_out,
  output logic signed [DATA_BITS-1:0] vel_b_out,
  output logic signed [DATA_BITS-1:0] vel_c_out,
  output logic signed [DATA_BITS-1:0] mag_a_out,
  output logic signed [DATA_BITS-1:0] mag_b_out,
  output logic signed [DATA_BITS-1:0] mag_c_out
);
  import svbr_pkg::*;

  localparam int COEF_BITS = ((61 - DATA_BITS) < 30) ? (61 - DATA_BITS) : 30;
  localparam int CW        = COEF_BITS + 2;
  localparam int PSH       = 60 - COEF_BITS;
  localparam int CSH       = 30 - COEF_BITS;
  localparam int TRIG_LAT  = 2 * TERMS + 3;
  localparam int LAT       = TRIG_LAT + 3;
  localparam int PASS_W    = 8 * DATA_BITS;

  dir_t direction;
  always_ff @(posedge clk) begin
    if (rst) direction <= DIR_CART_TO_SPH;
    else if (cfg_we) direction <= dir_t'(cfg_wdata);
  end

  // Pipeline advances whenever the output slot is free or being taken.
  logic en;
  logic [LAT-1:0] vld;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  // Delay line for the payload carried alongside the trig stages.
  logic [PASS_W-1:0] dly [TRIG_LAT+1];
  assign dly[0] = {density_in, pressure_in, vel_a_in, vel_b_in, vel_c_in,
                   mag_a_in, mag_b_in, mag_c_in};
  for (genvar d = 1; d <= TRIG_LAT; d++) begin : g_dly
    always_ff @(posedge clk) if (en) dly[d] <= dly[d-1];
  end
  logic [PASS_W-1:0] pass2, pass3;
  always_ff @(posedge clk) begin
    if (en) begin
      pass2 <= dly[TRIG_LAT];
      pass3 <= pass2;
    end
  end

  // Sine and cosine of both angles.
  logic signed [31:0] st, ct, sp, cp;
  svbr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_polar (
    .clk(clk), .en(en), .angle(polar_angle), .sin_q30(st), .cos_q30(ct));
  svbr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_azim (
    .clk(clk), .en(en), .angle(azimuth_angle), .sin_q30(sp), .cos_q30(cp));

  // Matrix entries, products rounded once from Q60.
  function automatic logic signed [CW-1:0] rnd_p(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (PSH - 1))) >>> PSH;
    return CW'(t);
  endfunction
  function automatic logic signed [CW-1:0] rnd_c(input logic signed [31:0] v);
    logic signed [32:0] t;
    if (CSH == 0) t = 33'(v);
    else t = (33'(v) + (33'sd1 <<< (CSH - 1))) >>> CSH;
    return CW'(t);
  endfunction

  logic signed [CW-1:0] m [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      m[0][0] <= rnd_p(64'(st) * 64'(cp));
      m[0][1] <= rnd_p(64'(st) * 64'(sp));
      m[0][2] <= rnd_c(ct);
      m[1][0] <= rnd_p(64'(ct) * 64'(cp));
      m[1][1] <= rnd_p(64'(ct) * 64'(sp));
      m[1][2] <= rnd_c(-st);
      m[2][0] <= rnd_c(-sp);
      m[2][1] <= rnd_c(cp);
      m[2][2] <= '0;
    end
  end

  // Two lanes, one per vector.
  logic signed [DATA_BITS-1:0] vel_v [3], mag_v [3], vel_o [3], mag_o [3];
  assign vel_v[0] = pass2[5*DATA_BITS +: DATA_BITS];
  assign vel_v[1] = pass2[4*DATA_BITS +: DATA_BITS];
  assign vel_v[2] = pass2[3*DATA_BITS +: DATA_BITS];
  assign mag_v[0] = pass2[2*DATA_BITS +: DATA_BITS];
  assign mag_v[1] = pass2[1*DATA_BITS +: DATA_BITS];
  assign mag_v[2] = pass2[0 +: DATA_BITS];

  svbr_lane #(.DATA_BITS(DATA_BITS), .COEF_BITS(COEF_BITS)) u_vel (
    .clk(clk), .en(en), .m(m), .transpose(direction == DIR_SPH_TO_CART),
    .vin(vel_v), .vout(vel_o));
  svbr_lane #(.DATA_BITS(DATA_BITS), .COEF_BITS(COEF_BITS)) u_mag (
    .clk(clk), .en(en), .m(m), .transpose(direction == DIR_SPH_TO_CART),
    .vin(mag_v), .vout(mag_o));

  // Merge pass-through and rotated fields into the output register.
  logic [2*DATA_BITS-1:0] dp4;
  always_ff @(posedge clk) if (en) dp4 <= pass3[PASS_W-1 -: 2*DATA_BITS];

  assign density_out  = dp4[2*DATA_BITS-1 -: DATA_BITS];
  assign pressure_out = dp4[DATA_BITS-1:0];
  assign vel_a_out = vel_o[0];
  assign vel_b_out = vel_o[1];
  assign vel_c_out = vel_o[2];
  assign mag_a_out = mag_o[0];
  assign mag_b_out = mag_o[1];
  assign mag_c_out = mag_o[2];
endmodule

// File: hdl/svbr_checker.sv
`include "assert_macros.svh"

// Port-level checks for the rotation block.
module svbr_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_IMPLY(a_ready_free, clk, rst, !out_valid, in_ready, "input stalled with empty output")
  `CHK_IMPLY(a_ready_stall, clk, rst, out_valid && !out_ready, !in_ready,
             "input taken while output stalled")
  `CHK_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result after reset")
endmodule

bind spherical_vector_basis_rotation svbr_checker u_svbr_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready));

// File: verif/testbench.sv
module testbench;
  import svbr_pkg::*;

  localparam int AB = 16;
  localparam int DB = 32;
  localparam int COEF = ((61 - DB) < 30) ? (61 - DB) : 30;
  localparam int LATENCY = 28;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint PI_Q = 64'hC90FDAA2;
  localparam longint ONE_Q = 64'h40000000;

  typedef struct packed {
    logic [AB-1:0] polar;
    logic [AB-1:0] azim;
    logic signed [DB-1:0] dens;
    logic signed [DB-1:0] pres;
    logic signed [DB-1:0] va, vb, vc;
    logic signed [DB-1:0] ma, mb, mc;
  } point_t;

  typedef struct packed {
    logic signed [DB-1:0] dens;
    logic signed [DB-1:0] pres;
    logic signed [DB-1:0] va, vb, vc;
    logic signed [DB-1:0] ma, mb, mc;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  point_t drv = '0;
  rotated_t got;

  dir_t cur_dir = DIR_CART_TO_SPH;
  rotated_t pending_rot[$];
  int errors = 0;
  longint cycles = 0;
  bit random_stall = 1'b1;

  spherical_vector_basis_rotation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .polar_angle(drv.polar), .azimuth_angle(drv.azim),
    .density_in(drv.dens), .pressure_in(drv.pres),
    .vel_a_in(drv.va), .vel_b_in(drv.vb), .vel_c_in(drv.vc),
    .mag_a_in(drv.ma), .mag_b_in(drv.mb), .mag_c_in(drv.mc),
    .out_valid(out_valid), .out_ready(out_ready),
    .density_out(got.dens), .pressure_out(got.pres),
    .vel_a_out(got.va), .vel_b_out(got.vb), .vel_c_out(got.vc),
    .mag_a_out(got.ma), .mag_b_out(got.mb), .mag_c_out(got.mc)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Round half up division by a power of two.
  function automatic longint round_shift(longint v, int sh);
    longint b;
    if (sh == 0) return v;
    b = longint'(1) <<< (sh - 1);
    return (v + b) >>> sh;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q) return ONE_Q;
    return v;
  endfunction

  // Sine and cosine in Q30 by a truncated Taylor series per quadrant.
  function automatic void trig_q30(input logic [AB-1:0] ang, output longint s,
                                   output longint c);
    logic [1:0] quad;
    longint unsigned r, x, x2, ts, tc;
    longint ss, cs, s0, c0;
    quad = ang[AB-1 -: 2];
    r = ang & ((1 << (AB - 2)) - 1);
    x = (r * PI_Q + (longint'(1) << (AB - 2))) >> (AB - 1);
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q;
    ss = x;
    cs = ONE_Q;
    for (int k = 1; k <= 11; k++) begin
      ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2) begin
        ss -= ts;
        cs -= tc;
      end else begin
        ss += ts;
        cs += tc;
      end
    end
    s0 = clamp_unit(ss);
    c0 = clamp_unit(cs);
    case (quad)
      2'd0: begin s = s0; c = c0; end
      2'd1: begin s = c0; c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic logic signed [DB-1:0] sat_data(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (DB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return DB'(hi);
    if (v < lo) return DB'(lo);
    return v[DB-1:0];
  endfunction

  function automatic rotated_t rotate_point(point_t p, dir_t dir);
    longint st, ct, sp, cp, acc;
    longint m[3][3];
    longint vel[3], mag[3];
    logic signed [DB-1:0] vo[3], mo[3];
    rotated_t o;
    trig_q30(p.polar, st, ct);
    trig_q30(p.azim, sp, cp);
    m[0][0] = round_shift(st * cp, 60 - COEF);
    m[0][1] = round_shift(st * sp, 60 - COEF);
    m[0][2] = round_shift(ct, 30 - COEF);
    m[1][0] = round_shift(ct * cp, 60 - COEF);
    m[1][1] = round_shift(ct * sp, 60 - COEF);
    m[1][2] = round_shift(-st, 30 - COEF);
    m[2][0] = round_shift(-sp, 30 - COEF);
    m[2][1] = round_shift(cp, 30 - COEF);
    m[2][2] = 0;
    vel[0] = p.va; vel[1] = p.vb; vel[2] = p.vc;
    mag[0] = p.ma; mag[1] = p.mb; mag[2] = p.mc;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += vel[j] * ((dir == DIR_SPH_TO_CART) ? m[j][i] : m[i][j]);
      vo[i] = sat_data(round_shift(acc, COEF));
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += mag[j] * ((dir == DIR_SPH_TO_CART) ? m[j][i] : m[i][j]);
      mo[i] = sat_data(round_shift(acc, COEF));
    end
    o.dens = p.dens;
    o.pres = p.pres;
    o.va = vo[0]; o.vb = vo[1]; o.vc = vo[2];
    o.ma = mo[0]; o.mb = mo[1]; o.mc = mo[2];
    return o;
  endfunction

  task automatic report(input string what, input logic [DB-1:0] g, input logic [DB-1:0] e);
    $display("mismatch %s: got %h expected %h", what, g, e);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 25);
  endfunction

  // Send one point and predict its rotated result on transfer.
  task automatic send_point(input point_t p);
    int g;
    g = random_stall ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    drv <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_rot.push_back(rotate_point(p, cur_dir));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rot.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_direction(input dir_t d);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_dir = d;
  endtask

  function automatic logic signed [DB-1:0] rand_data();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 20) << 16;
      3: return -($urandom_range(0, 20) << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.polar = ($urandom_range(0, 7) == 0) ? AB'($urandom) : AB'($urandom_range(0, 32768));
    p.azim = AB'($urandom);
    p.dens = $urandom; p.pres = $urandom;
    p.va = rand_data(); p.vb = rand_data(); p.vc = rand_data();
    p.ma = rand_data(); p.mb = rand_data(); p.mc = rand_data();
    return p;
  endfunction

  // Angles at and beside quadrant boundaries, with full-scale and small components.
  task automatic test_directed(input dir_t d);
    point_t p;
    logic [AB-1:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
    set_direction(d);
    for (int i = 0; i < 6; i++) begin
      p.polar = angs[i];
      p.azim = angs[5 - i];
      p.dens = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      p.pres = ~p.dens;
      p.va = 32'sh7fffffff; p.vb = 32'sh7fffffff; p.vc = 32'sh7fffffff;
      p.ma = 32'sh80000000; p.mb = 32'sh80000000; p.mc = 32'sh80000000;
      if (i > 3) begin
        p.va = 32'sh00010000; p.vb = 0; p.vc = -32'sh00010000;
        p.ma = 32'sh80000000; p.mb = 32'sh7fffffff; p.mc = 32'sh80000000;
      end
      send_point(p);
    end
  endtask

  task automatic test_random(input dir_t d, input int n);
    set_direction(d);
    for (int i = 0; i < n; i++) send_point(rand_point());
  endtask

  // Back to back transfers with the receiver always ready.
  task automatic test_streaming();
    random_stall = 1'b0;
    test_random(DIR_CART_TO_SPH, 60);
    random_stall = 1'b1;
  endtask

  // The receiver stalls at random with short and long waits.
  initial begin
    forever begin
      @(negedge clk);
      if (!random_stall) out_ready <= 1'b1;
      else if ($urandom_range(0, 9) < 6) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (1 + gap_len()) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  initial begin
    rotated_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_rot.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          e = pending_rot.pop_front();
          if (got.dens !== e.dens) report("density", got.dens, e.dens);
          if (got.pres !== e.pres) report("pressure", got.pres, e.pres);
          if (got.va !== e.va) report("vel_a", got.va, e.va);
          if (got.vb !== e.vb) report("vel_b", got.vb, e.vb);
          if (got.vc !== e.vc) report("vel_c", got.vc, e.vc);
          if (got.ma !== e.ma) report("mag_a", got.ma, e.ma);
          if (got.mb !== e.mb) report("mag_b", got.mb, e.mb);
          if (got.mc !== e.mc) report("mag_c", got.mc, e.mc);
        end
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[spherical_vector_basis_rotation] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed(DIR_CART_TO_SPH);
    test_directed(DIR_SPH_TO_CART);
    test_random(DIR_SPH_TO_CART, 130);
    test_random(DIR_CART_TO_SPH, 130);
    test_streaming();
    test_random(DIR_SPH_TO_CART, 120);
    drain();
    if (errors == 0)
      $display("[spherical_vector_basis_rotation] OK");
    else
      $display("[spherical_vector_basis_rotation] ERROR");
    $finish;
  end
endmodule
